>>> rtl/assert_macros.svh
// Assertion macros used by the countdown timer top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Implication or sequence property, checked at every rising edge outside reset.
`define CDT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed: property violated");
// Condition that must never be seen at a rising edge outside reset.
`define CDT_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("assertion failed: forbidden condition seen");
`else
`define CDT_ASSERT(lbl, clk, rst_n, prop)
`define CDT_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

>>> rtl/cdt_pkg.sv
// Types, codes and helper functions of the countdown timer.
`default_nettype none
package cdt_pkg;

    localparam int OPCODE_W  = 3;
    localparam int MINUTES_W = 16;
    localparam int KIND_W    = 2;
    localparam int STATE_W   = 3;
    localparam int FB_W      = 2;
    localparam int PLAN_W    = 22;
    localparam int ELAP_W    = 32;
    localparam int MAX_RES   = 4;
    localparam int CNT_W     = $clog2(MAX_RES + 1);
    localparam int SECS_PER_MIN = 60;

    typedef enum logic [OPCODE_W-1:0] {
        OP_SET_TIME = 3'd0,
        OP_START    = 3'd1,
        OP_PAUSE    = 3'd2,
        OP_RESUME   = 3'd3,
        OP_STOP     = 3'd4,
        OP_RESET    = 3'd5,
        OP_TICK     = 3'd6
    } t_opcode;

    typedef enum logic [STATE_W-1:0] {
        ST_IDLE     = 3'd0,
        ST_RUNNING  = 3'd1,
        ST_OVERTIME = 3'd2,
        ST_PAUSED   = 3'd3,
        ST_FINISHED = 3'd4
    } t_state;

    typedef enum logic [KIND_W-1:0] {
        KIND_CHANGE   = 2'd0,
        KIND_FEEDBACK = 2'd1,
        KIND_TICK     = 2'd2,
        KIND_SLIP     = 2'd3
    } t_kind;

    typedef enum logic [FB_W-1:0] {
        FB_START  = 2'd0,
        FB_STOP   = 2'd1,
        FB_RESET  = 2'd2,
        FB_TIMEUP = 2'd3
    } t_fb;

    // One result item
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [STATE_W-1:0] prev_state;
        logic [STATE_W-1:0] next_state;
        logic [FB_W-1:0]    feedback_code;
        logic [PLAN_W-1:0]  planned_seconds;
        logic [ELAP_W-1:0]  elapsed_seconds;
        logic [PLAN_W-1:0]  remaining_seconds;
        logic [ELAP_W-1:0]  overrun_seconds;
        logic               last;
    } t_result;

    // All results of one event, handed from the core to the output queue
    typedef struct packed {
        logic                        load;
        logic [CNT_W-1:0]            cnt;
        t_result [MAX_RES-1:0]       res;
    } t_batch;

    function automatic t_result mk_change(input t_state prev, input t_state nxt);
        t_result r;
        r            = '0;
        r.kind       = KIND_CHANGE;
        r.prev_state = prev;
        r.next_state = nxt;
        return r;
    endfunction

    function automatic t_result mk_feedback(input t_fb code);
        t_result r;
        r               = '0;
        r.kind          = KIND_FEEDBACK;
        r.feedback_code = code;
        return r;
    endfunction

    function automatic t_result mk_report(input t_kind kind,
                                          input logic [PLAN_W-1:0] plan,
                                          input logic [ELAP_W-1:0] elap,
                                          input logic [PLAN_W-1:0] rem,
                                          input logic [ELAP_W-1:0] over);
        t_result r;
        r                   = '0;
        r.kind              = kind;
        r.planned_seconds   = plan;
        r.elapsed_seconds   = elap;
        r.remaining_seconds = rem;
        r.overrun_seconds   = over;
        return r;
    endfunction

endpackage
`default_nettype wire

>>> rtl/cdt_evt_if.sv
// Event channel: valid/ready handshake carrying one timer event.
`default_nettype none
interface cdt_evt_if;
    logic                          valid;
    logic                          ready;
    logic [cdt_pkg::OPCODE_W-1:0]  opcode;
    logic [cdt_pkg::MINUTES_W-1:0] minutes;

    modport source (output valid, output opcode, output minutes, input ready);
    modport sink   (input valid, input opcode, input minutes, output ready);
endinterface
`default_nettype wire

>>> rtl/cdt_res_if.sv
// Result channel: valid/ready handshake carrying one timer result.
`default_nettype none
interface cdt_res_if;
    logic                        valid;
    logic                        ready;
    logic [cdt_pkg::KIND_W-1:0]  kind;
    logic [cdt_pkg::STATE_W-1:0] prev_state;
    logic [cdt_pkg::STATE_W-1:0] next_state;
    logic [cdt_pkg::FB_W-1:0]    feedback_code;
    logic [cdt_pkg::PLAN_W-1:0]  planned_seconds;
    logic [cdt_pkg::ELAP_W-1:0]  elapsed_seconds;
    logic [cdt_pkg::PLAN_W-1:0]  remaining_seconds;
    logic [cdt_pkg::ELAP_W-1:0]  overrun_seconds;
    logic                        last;

    modport source (output valid, output kind, output prev_state, output next_state,
                    output feedback_code, output planned_seconds, output elapsed_seconds,
                    output remaining_seconds, output overrun_seconds, output last,
                    input ready);
    modport sink   (input valid, input kind, input prev_state, input next_state,
                    input feedback_code, input planned_seconds, input elapsed_seconds,
                    input remaining_seconds, input overrun_seconds, input last,
                    output ready);
endinterface
`default_nettype wire

>>> rtl/cdt_core.sv
// Event register, timer state and the builder of each event's result list.
`default_nettype none
module cdt_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic [cdt_pkg::OPCODE_W-1:0]  i_opcode,
    input  wire logic [cdt_pkg::MINUTES_W-1:0] i_minutes,
    output logic                               o_ready,
    input  wire logic                          i_free,
    output cdt_pkg::t_batch                    o_batch
);
    import cdt_pkg::*;

    logic                 r_in_valid;
    logic [OPCODE_W-1:0]  r_opcode;
    logic [MINUTES_W-1:0] r_minutes;

    t_state               r_state,     n_state;
    t_state               r_resume,    n_resume;
    logic [PLAN_W-1:0]    r_planned,   n_planned;
    logic [ELAP_W-1:0]    r_elapsed,   n_elapsed;
    logic [PLAN_W-1:0]    r_remaining, n_remaining;
    logic [ELAP_W-1:0]    r_overrun,   n_overrun;

    logic                 w_commit;
    logic                 w_active;
    logic                 w_sat;
    logic [PLAN_W-1:0]    w_plan_set;
    logic [ELAP_W-1:0]    w_tick_elapsed;
    logic [PLAN_W-1:0]    w_tick_rem;
    logic [ELAP_W-1:0]    w_tick_over;
    t_result [MAX_RES-1:0] w_res;
    logic [CNT_W-1:0]     w_cnt;

    // Event leaves the input register once the output queue can take its results
    assign w_commit = r_in_valid && i_free;
    assign o_ready  = !r_in_valid || w_commit;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_opcode  <= i_opcode;
            r_minutes <= i_minutes;
        end
    end

    // Helpers: plan from minutes, and the counts after one tick.
    // Remaining and overrun are kept as running counts so a tick is one step.
    assign w_active       = (r_state == ST_RUNNING) || (r_state == ST_OVERTIME);
    assign w_plan_set     = PLAN_W'(r_minutes) * PLAN_W'(SECS_PER_MIN);
    assign w_sat          = &r_elapsed;
    assign w_tick_elapsed = w_sat ? r_elapsed : r_elapsed + ELAP_W'(1);
    assign w_tick_rem     = (w_sat || r_remaining == '0) ? r_remaining
                                                         : r_remaining - PLAN_W'(1);
    assign w_tick_over    = (w_sat || r_remaining != '0) ? r_overrun
                                                         : r_overrun + ELAP_W'(1);

    // Event decode: next timer state and the ordered result list
    always_comb begin
        n_state     = r_state;
        n_resume    = r_resume;
        n_planned   = r_planned;
        n_elapsed   = r_elapsed;
        n_remaining = r_remaining;
        n_overrun   = r_overrun;
        w_res       = '0;
        w_cnt       = '0;
        unique case (t_opcode'(r_opcode))
            OP_SET_TIME: begin
                if (r_state == ST_IDLE) begin
                    n_planned   = w_plan_set;
                    n_elapsed   = '0;
                    n_remaining = w_plan_set;
                    n_overrun   = '0;
                    w_res[0]    = mk_report(KIND_TICK, w_plan_set, '0, w_plan_set, '0);
                    w_cnt       = CNT_W'(1);
                end
            end
            OP_START: begin
                if (r_state == ST_IDLE && r_planned != '0) begin
                    n_state     = ST_RUNNING;
                    n_elapsed   = '0;
                    n_remaining = r_planned;
                    n_overrun   = '0;
                    w_res[0]    = mk_change(ST_IDLE, ST_RUNNING);
                    w_res[1]    = mk_feedback(FB_START);
                    w_res[2]    = mk_report(KIND_TICK, r_planned, '0, r_planned, '0);
                    w_cnt       = CNT_W'(3);
                end
            end
            OP_PAUSE: begin
                if (w_active) begin
                    n_resume = r_state;
                    n_state  = ST_PAUSED;
                    w_res[0] = mk_change(r_state, ST_PAUSED);
                    w_cnt    = CNT_W'(1);
                end
            end
            OP_RESUME: begin
                if (r_state == ST_PAUSED) begin
                    n_state  = r_resume;
                    w_res[0] = mk_change(ST_PAUSED, r_resume);
                    w_cnt    = CNT_W'(1);
                end
            end
            OP_STOP: begin
                // Passes through finished on the way back to idle
                if (w_active || r_state == ST_PAUSED) begin
                    n_state  = ST_IDLE;
                    w_res[0] = mk_change(r_state, ST_FINISHED);
                    w_res[1] = mk_feedback(FB_STOP);
                    w_res[2] = mk_report(KIND_SLIP, r_planned, r_elapsed, '0, r_overrun);
                    w_res[3] = mk_change(ST_FINISHED, ST_IDLE);
                    w_cnt    = CNT_W'(4);
                end
            end
            OP_RESET: begin
                n_state     = ST_IDLE;
                n_planned   = '0;
                n_elapsed   = '0;
                n_remaining = '0;
                n_overrun   = '0;
                w_res[0]    = mk_feedback(FB_RESET);
                // No state change when already idle
                if (r_state == ST_IDLE) begin
                    w_res[1] = mk_report(KIND_TICK, '0, '0, '0, '0);
                    w_cnt    = CNT_W'(2);
                end else begin
                    w_res[1] = mk_change(r_state, ST_IDLE);
                    w_res[2] = mk_report(KIND_TICK, '0, '0, '0, '0);
                    w_cnt    = CNT_W'(3);
                end
            end
            OP_TICK: begin
                if (w_active) begin
                    n_elapsed   = w_tick_elapsed;
                    n_remaining = w_tick_rem;
                    n_overrun   = w_tick_over;
                    // Time up: running and the plan is reached
                    if (r_state == ST_RUNNING && w_tick_rem == '0) begin
                        n_state  = ST_OVERTIME;
                        w_res[0] = mk_change(ST_RUNNING, ST_OVERTIME);
                        w_res[1] = mk_feedback(FB_TIMEUP);
                        w_res[2] = mk_report(KIND_TICK, r_planned, w_tick_elapsed,
                                             w_tick_rem, w_tick_over);
                        w_cnt    = CNT_W'(3);
                    end else begin
                        w_res[0] = mk_report(KIND_TICK, r_planned, w_tick_elapsed,
                                             w_tick_rem, w_tick_over);
                        w_cnt    = CNT_W'(1);
                    end
                end
            end
            default: begin
                // Undefined opcode: ignored
            end
        endcase
        // Mark the final result of the event
        for (int k = 0; k < MAX_RES; k++) begin
            if (CNT_W'(k + 1) == w_cnt) begin
                w_res[k].last = 1'b1;
            end
        end
    end

    // Timer state registers, updated when the event commits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_resume    <= ST_RUNNING;
            r_planned   <= '0;
            r_elapsed   <= '0;
            r_remaining <= '0;
            r_overrun   <= '0;
        end else if (w_commit) begin
            r_state     <= n_state;
            r_resume    <= n_resume;
            r_planned   <= n_planned;
            r_elapsed   <= n_elapsed;
            r_remaining <= n_remaining;
            r_overrun   <= n_overrun;
        end
    end

    assign o_batch.load = w_commit;
    assign o_batch.cnt  = w_cnt;
    assign o_batch.res  = w_res;

endmodule
`default_nettype wire

>>> rtl/cdt_seq.sv
// Result queue of one event and the output register that presents one result a cycle while the receiver is ready.
`default_nettype none
module cdt_seq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire cdt_pkg::t_batch i_batch,
    output logic                 o_free,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output cdt_pkg::t_result     o_res
);
    import cdt_pkg::*;

    t_result [MAX_RES-1:0] r_q;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_out_valid;
    t_result               r_out;
    logic                  w_out_load;

    // Move the head result into the output register when it is empty or taken
    assign w_out_load = (r_cnt != '0) && (!r_out_valid || i_ready);
    assign o_free     = (r_cnt == '0) || (r_cnt == CNT_W'(1) && w_out_load);

    // Queue: load a new list, or shift down as results leave
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_batch.load) begin
            r_cnt <= i_batch.cnt;
        end else if (w_out_load) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
        if (i_batch.load) begin
            r_q <= i_batch.res;
        end else if (w_out_load) begin
            for (int k = 0; k < MAX_RES - 1; k++) begin
                r_q[k] <= r_q[k + 1];
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_out_load) begin
            r_out <= r_q[0];
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

endmodule
`default_nettype wire

>>> rtl/countdown_timer_with_overtime.sv
// Top level of the countdown timer with overtime.
//
//  channel | dir | modport | transaction
//  i_evt   | in  | sink    | one event: opcode, minutes
//  o_res   | out | source  | one result: kind, states, feedback, counts, last
//
// An event is decoded in the cycle after its transaction, enters the result
// queue once the queue can take its results, and its first result then passes
// through the output register onto o_res. Results leave the output register
// in order as o_res takes them. A new event is taken while results of the
// previous one still drain. Reset clears the timer state and all valid flags
// at once; there is no clearing pass. Stalls on o_res back up through the
// result queue into the event register.
`default_nettype none
`include "assert_macros.svh"
module countdown_timer_with_overtime (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cdt_evt_if.sink    i_evt,
    cdt_res_if.source  o_res
);
    import cdt_pkg::*;

    t_batch  w_batch;
    logic    w_free;
    logic    w_out_valid;
    t_result w_out;

    // Event decode and timer state
    cdt_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_evt.valid),
        .i_opcode  (i_evt.opcode),
        .i_minutes (i_evt.minutes),
        .o_ready   (i_evt.ready),
        .i_free    (w_free),
        .o_batch   (w_batch)
    );

    // Result queue and output register
    cdt_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_batch (w_batch),
        .o_free  (w_free),
        .o_valid (w_out_valid),
        .i_ready (o_res.ready),
        .o_res   (w_out)
    );

    // Result channel
    assign o_res.valid             = w_out_valid;
    assign o_res.kind              = w_out.kind;
    assign o_res.prev_state        = w_out.prev_state;
    assign o_res.next_state        = w_out.next_state;
    assign o_res.feedback_code     = w_out.feedback_code;
    assign o_res.planned_seconds   = w_out.planned_seconds;
    assign o_res.elapsed_seconds   = w_out.elapsed_seconds;
    assign o_res.remaining_seconds = w_out.remaining_seconds;
    assign o_res.overrun_seconds   = w_out.overrun_seconds;
    assign o_res.last              = w_out.last;

    // An event with more results to come keeps the output busy the next cycle
    `CDT_ASSERT(a_burst_unbroken, i_clk, i_rst_n,
                (o_res.valid && o_res.ready && !o_res.last) |=> o_res.valid)
    // A new list is only loaded when the queue can take it
    `CDT_ASSERT(a_load_when_free, i_clk, i_rst_n, w_batch.load |-> w_free)
    // A held event register never commits
    `CDT_ASSERT(a_no_commit_stalled, i_clk, i_rst_n, !i_evt.ready |-> !w_batch.load)
    // No event yields more results than the queue holds
    `CDT_ASSERT_NEVER(a_cnt_bound, i_clk, i_rst_n, w_batch.load && (w_batch.cnt > CNT_W'(MAX_RES)))

endmodule
`default_nettype wire

>>> dv/countdown_timer_with_overtime_test.sv
// Self-checking testbench of the countdown timer: a directed table, then random event sessions.
`timescale 1ns / 100ps
`default_nettype none
module countdown_timer_with_overtime_test;
    import cdt_pkg::*;

    localparam logic [OPCODE_W-1:0] OP_UNDEFINED = 3'd7;
    localparam int RANDOM_ITEMS = 200;
    localparam int CALM_ITEMS   = 40;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 12;
    localparam int LIMIT        = 200000;
    localparam t_result NO_RES  = '0;

    // One row of the directed table; n_typed < 0 means the predictor supplies the results
    typedef struct {
        logic [OPCODE_W-1:0]  op;
        logic [MINUTES_W-1:0] mins;
        int                   reps;
        int                   n_typed;
        t_result              typed0;
        t_result              typed1;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cdt_evt_if evt_ch();
    cdt_res_if res_ch();

    countdown_timer_with_overtime DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (evt_ch),
        .o_res   (res_ch)
    );

    always #5 i_clk = ~i_clk;

    // Predicted timer state
    t_state             pred_state;
    t_state             pred_resume;
    logic [PLAN_W-1:0]  pred_planned;
    logic [ELAP_W-1:0]  pred_elapsed;

    t_result   event_out[$];
    t_result   pending_results[$];
    t_stim_row stim_table[$];

    int  err_count        = 0;
    int  results_checked  = 0;
    int  events_sent      = 0;
    int  effective_count  = 0;
    int  cycle_cnt        = 0;
    bit  calm             = 1'b0;
    bit  hold_request     = 1'b0;

    function automatic t_result res_of(input t_kind kind, input t_state prev, input t_state nxt,
                                       input t_fb fb, input logic [PLAN_W-1:0] plan,
                                       input logic [ELAP_W-1:0] elap,
                                       input logic [PLAN_W-1:0] rem,
                                       input logic [ELAP_W-1:0] over, input logic last);
        t_result r;
        r                   = '0;
        r.kind              = kind;
        r.prev_state        = prev;
        r.next_state        = nxt;
        r.feedback_code     = fb;
        r.planned_seconds   = plan;
        r.elapsed_seconds   = elap;
        r.remaining_seconds = rem;
        r.overrun_seconds   = over;
        r.last              = last;
        return r;
    endfunction

    // State change report; a change to the same state reports nothing
    function automatic void note_change(input t_state nxt);
        t_result r;
        if (nxt == pred_state) return;
        r            = '0;
        r.kind       = KIND_CHANGE;
        r.prev_state = pred_state;
        r.next_state = nxt;
        pred_state   = nxt;
        event_out.push_back(r);
    endfunction

    function automatic void note_feedback(input t_fb code);
        t_result r;
        r               = '0;
        r.kind          = KIND_FEEDBACK;
        r.feedback_code = code;
        event_out.push_back(r);
    endfunction

    function automatic logic [ELAP_W-1:0] overrun_of();
        return (pred_elapsed > ELAP_W'(pred_planned)) ? pred_elapsed - ELAP_W'(pred_planned) : '0;
    endfunction

    function automatic void note_tick();
        t_result r;
        r                   = '0;
        r.kind              = KIND_TICK;
        r.planned_seconds   = pred_planned;
        r.elapsed_seconds   = pred_elapsed;
        r.remaining_seconds = (pred_elapsed < ELAP_W'(pred_planned)) ?
                              PLAN_W'(ELAP_W'(pred_planned) - pred_elapsed) : '0;
        r.overrun_seconds   = overrun_of();
        event_out.push_back(r);
    endfunction

    // Results of one event, in order, into event_out
    function automatic void predict_event(input logic [OPCODE_W-1:0] op,
                                          input logic [MINUTES_W-1:0] mins);
        logic    active;
        t_result r;
        active = (pred_state == ST_RUNNING) || (pred_state == ST_OVERTIME);
        event_out.delete();
        case (op)
            OP_SET_TIME: begin
                if (pred_state == ST_IDLE) begin
                    pred_planned = PLAN_W'(32'(mins) * SECS_PER_MIN);
                    pred_elapsed = '0;
                    note_tick();
                end
            end
            OP_START: begin
                if (pred_state == ST_IDLE && pred_planned != '0) begin
                    pred_elapsed = '0;
                    note_change(ST_RUNNING);
                    note_feedback(FB_START);
                    note_tick();
                end
            end
            OP_PAUSE: begin
                if (active) begin
                    pred_resume = pred_state;
                    note_change(ST_PAUSED);
                end
            end
            OP_RESUME: begin
                if (pred_state == ST_PAUSED) note_change(pred_resume);
            end
            OP_STOP: begin
                if (active || pred_state == ST_PAUSED) begin
                    note_change(ST_FINISHED);
                    note_feedback(FB_STOP);
                    r                 = '0;
                    r.kind            = KIND_SLIP;
                    r.planned_seconds = pred_planned;
                    r.elapsed_seconds = pred_elapsed;
                    r.overrun_seconds = overrun_of();
                    event_out.push_back(r);
                    note_change(ST_IDLE);
                end
            end
            OP_RESET: begin
                pred_planned = '0;
                pred_elapsed = '0;
                note_feedback(FB_RESET);
                note_change(ST_IDLE);
                note_tick();
            end
            OP_TICK: begin
                if (active) begin
                    // elapsed count saturates
                    if (pred_elapsed != '1) pred_elapsed = pred_elapsed + 1'b1;
                    if (pred_state == ST_RUNNING && pred_elapsed >= ELAP_W'(pred_planned)) begin
                        note_change(ST_OVERTIME);
                        note_feedback(FB_TIMEUP);
                    end
                    note_tick();
                end
            end
            default: ;
        endcase
        if (event_out.size() > 0) event_out[event_out.size()-1].last = 1'b1;
    endfunction

    function automatic void add_row(input logic [OPCODE_W-1:0] op,
                                    input logic [MINUTES_W-1:0] mins, input int reps,
                                    input int n_typed, input t_result e0, input t_result e1);
        t_stim_row row;
        row.op      = op;
        row.mins    = mins;
        row.reps    = reps;
        row.n_typed = n_typed;
        row.typed0  = e0;
        row.typed1  = e1;
        stim_table.push_back(row);
    endfunction

    // Offer one event, wait for its transaction, then queue the predicted results
    task automatic send_event(input logic [OPCODE_W-1:0] op, input logic [MINUTES_W-1:0] mins);
        if (!calm && $urandom_range(0, 3) == 0) begin
            evt_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        evt_ch.valid   <= 1'b1;
        evt_ch.opcode  <= op;
        evt_ch.minutes <= mins;
        do @(posedge i_clk); while (!evt_ch.ready);
        predict_event(op, mins);
        foreach (event_out[i]) pending_results.push_back(event_out[i]);
        events_sent++;
        if (event_out.size() > 0) effective_count++;
    endtask

    task automatic wait_for_drain();
        evt_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    // One well-formed run of the timer with random content
    task automatic run_session();
        int                   pick;
        int                   ticks;
        logic [MINUTES_W-1:0] mins;
        if (pred_state != ST_IDLE) send_event(OP_RESET, 16'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 60)      mins = 16'd1;
        else if (pick < 72) mins = 16'd0;
        else if (pick < 88) mins = 16'($urandom_range(2, 3));
        else                mins = 16'($urandom);
        send_event(OP_SET_TIME, mins);
        send_event(OP_START, 16'($urandom));
        ticks = (mins == 16'd1) ? $urandom_range(45, 75) : $urandom_range(10, 30);
        for (int t = 0; t < ticks; t++) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                send_event(OP_PAUSE, 16'($urandom));
                repeat ($urandom_range(0, 2)) send_event(OP_TICK, 16'($urandom));
                send_event(OP_RESUME, 16'($urandom));
            end else if (pick < 9) begin
                send_event(3'($urandom_range(0, 7)), 16'($urandom));
            end
            send_event(OP_TICK, 16'($urandom));
        end
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            send_event(OP_STOP, 16'($urandom));
        end else if (pick < 80) begin
            send_event(OP_RESET, 16'($urandom));
        end else begin
            send_event(OP_PAUSE, 16'($urandom));
            send_event(OP_STOP, 16'($urandom));
        end
    endtask

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            err_count++;
        end
    endfunction

    // Result checker
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with no expected result pending");
                err_count++;
            end else begin
                e = pending_results.pop_front();
                results_checked++;
                check_field("kind", 32'(e.kind), 32'(res_ch.kind));
                check_field("prev_state", 32'(e.prev_state), 32'(res_ch.prev_state));
                check_field("next_state", 32'(e.next_state), 32'(res_ch.next_state));
                check_field("feedback_code", 32'(e.feedback_code), 32'(res_ch.feedback_code));
                check_field("planned_seconds", 32'(e.planned_seconds),
                            32'(res_ch.planned_seconds));
                check_field("elapsed_seconds", e.elapsed_seconds, res_ch.elapsed_seconds);
                check_field("remaining_seconds", 32'(e.remaining_seconds),
                            32'(res_ch.remaining_seconds));
                check_field("overrun_seconds", e.overrun_seconds, res_ch.overrun_seconds);
                check_field("last", 32'(e.last), 32'(res_ch.last));
            end
        end
    end

    // Receiver: random stalls, one long hold on request, none in the calm tail
    initial begin
        res_ch.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 2) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    // Timeout
    always @(posedge i_clk) cycle_cnt <= cycle_cnt + 1;

    initial begin
        wait (cycle_cnt >= LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // Stimulus
    initial begin
        int base_sent;
        int n_pred;
        int session;
        i_rst_n        <= 1'b0;
        evt_ch.valid   <= 1'b0;
        evt_ch.opcode  <= OP_TICK;
        evt_ch.minutes <= '0;
        pred_state   = ST_IDLE;
        pred_resume  = ST_RUNNING;
        pred_planned = '0;
        pred_elapsed = '0;

        // Directed table; typed rows carry hand-written results, unused fields zero
        add_row(OP_RESET, 16'd0, 1, 2,
                res_of(KIND_FEEDBACK, ST_IDLE, ST_IDLE, FB_RESET, '0, 0, '0, 0, 1'b0),
                res_of(KIND_TICK, ST_IDLE, ST_IDLE, FB_START, '0, 0, '0, 0, 1'b1));
        add_row(OP_START, 16'd0, 1, 0, NO_RES, NO_RES);       // zero plan
        add_row(OP_TICK, 16'd0, 1, 0, NO_RES, NO_RES);
        add_row(OP_PAUSE, 16'd0, 1, 0, NO_RES, NO_RES);
        add_row(OP_RESUME, 16'd0, 1, 0, NO_RES, NO_RES);
        add_row(OP_STOP, 16'd0, 1, 0, NO_RES, NO_RES);
        add_row(OP_UNDEFINED, 16'hFFFF, 1, 0, NO_RES, NO_RES);
        add_row(OP_SET_TIME, 16'd0, 1, 1,
                res_of(KIND_TICK, ST_IDLE, ST_IDLE, FB_START, '0, 0, '0, 0, 1'b1), NO_RES);
        add_row(OP_SET_TIME, 16'hFFFF, 1, 1,
                res_of(KIND_TICK, ST_IDLE, ST_IDLE, FB_START, PLAN_W'(3932100), 0,
                       PLAN_W'(3932100), 0, 1'b1),
                NO_RES);
        add_row(OP_SET_TIME, 16'd1, 1, 1,
                res_of(KIND_TICK, ST_IDLE, ST_IDLE, FB_START, PLAN_W'(60), 0, PLAN_W'(60), 0,
                       1'b1), NO_RES);
        add_row(OP_START, 16'd0, 1, -1, NO_RES, NO_RES);
        add_row(OP_SET_TIME, 16'd5, 1, -1, NO_RES, NO_RES);   // not idle
        add_row(OP_START, 16'd0, 1, -1, NO_RES, NO_RES);      // already running
        add_row(OP_PAUSE, 16'd0, 1, -1, NO_RES, NO_RES);
        add_row(OP_TICK, 16'd0, 1, -1, NO_RES, NO_RES);       // paused
        add_row(OP_RESUME, 16'd0, 1, -1, NO_RES, NO_RES);
        add_row(OP_TICK, 16'h5555, 59, -1, NO_RES, NO_RES);
        add_row(OP_TICK, 16'hAAAA, 1, -1, NO_RES, NO_RES);    // time up
        add_row(OP_TICK, 16'd0, 2, -1, NO_RES, NO_RES);       // overtime
        add_row(OP_PAUSE, 16'd0, 1, -1, NO_RES, NO_RES);
        add_row(OP_RESUME, 16'd0, 1, -1, NO_RES, NO_RES);     // back to overtime
        add_row(OP_STOP, 16'd0, 1, -1, NO_RES, NO_RES);
        add_row(OP_START, 16'd0, 1, -1, NO_RES, NO_RES);      // plan kept after stop
        add_row(OP_TICK, 16'd0, 1, -1, NO_RES, NO_RES);
        add_row(OP_RESET, 16'd0, 1, -1, NO_RES, NO_RES);      // reset while running
        add_row(OP_SET_TIME, 16'd2, 1, -1, NO_RES, NO_RES);
        add_row(OP_START, 16'd0, 1, -1, NO_RES, NO_RES);
        add_row(OP_PAUSE, 16'd0, 1, -1, NO_RES, NO_RES);
        add_row(OP_STOP, 16'd0, 1, -1, NO_RES, NO_RES);       // stop while paused

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_table[i]) begin
            for (int k = 0; k < stim_table[i].reps; k++) begin
                send_event(stim_table[i].op, stim_table[i].mins);
                if (stim_table[i].n_typed >= 0) begin
                    // hand-written results stand in for the predicted ones
                    n_pred = event_out.size();
                    repeat (n_pred) void'(pending_results.pop_back());
                    if (stim_table[i].n_typed > 0) pending_results.push_back(stim_table[i].typed0);
                    if (stim_table[i].n_typed > 1) pending_results.push_back(stim_table[i].typed1);
                end
            end
        end

        // Random sessions and noise; the first one runs under a long receiver hold
        base_sent    = events_sent;
        session      = 0;
        hold_request = 1'b1;
        while (events_sent - base_sent < RANDOM_ITEMS) begin
            if (events_sent - base_sent >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
            if ($urandom_range(0, 99) < 15) begin
                repeat ($urandom_range(1, 8)) send_event(3'($urandom_range(0, 7)), 16'($urandom));
            end else begin
                run_session();
            end
            session++;
            if (session == 2) wait_for_drain();
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d events (%0d with results) and checked %0d results,", events_sent,
                 effective_count, results_checked);
        $display("including pause, overtime, stop and reset paths, a long output hold and a drain.");
        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
